/* sv/lssu_pkg.sv */
// Package: shared types, constants and helpers for the lattice step score update block.
`timescale 1ns / 1ps
package lssu_pkg;
	localparam int MaxVars = 64;
	localparam int MaxRows = 32;
	localparam int VarW = $clog2(MaxVars);
	localparam int RowW = $clog2(MaxRows);
	localparam int CntW = RowW + 1;

	typedef enum logic [2:0] {
		CMD_COEF  = 3'd0,
		CMD_RESID = 3'd1,
		CMD_VAR   = 3'd2,
		CMD_SCORE = 3'd3,
		CMD_STEP  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_NUM_EQ   = 2'd0,
		REG_NUM_INEQ = 2'd1,
		REG_BND_TOL  = 2'd2,
		REG_FEAS_TOL = 2'd3
	} reg_idx_t;

	// control states of the walker core
	typedef enum logic [2:0] {
		ST_IDLE, ST_VAR, ST_UPD, ST_CHK, ST_OUT
	} state_t;

	// saturate 48-bit signed to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
		else if (v < -48'sh0000_8000_0000) sat32 = 32'sh8000_0000;
		else sat32 = v[31:0];
	endfunction

	// saturate 49-bit sum to 48-bit signed
	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v[48] != v[47]) sat48 = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else sat48 = v[47:0];
	endfunction
endpackage

/* sv/lattice_step_score_update.sv */
// Top level: local-search walker core with memory-held state and row sweep.
//
// Usage: a command word is accepted when start is high and busy is low.
// Every command yields one result word on accepted/feasible/objective_value/
// out_of_bound_count, marked by done for exactly one cycle; the receiver
// cannot stall, so the result must be taken that cycle.
// A load or unknown command goes straight to the feasibility scan, which
// reads and then checks each active row in turn (at most 32 rows). A step
// does the variable read-modify-write, then the row residual update, each
// row read and written back through the residual and coefficient memories,
// then the same scan; a step that aborts skips the residual update.
// busy stays high through the done cycle, so no new command word is taken
// before the result word of the last one is out.
// Reset clears violations, the violation count, the objective score and
// the registers (0, 0, 1, 66); the memories are undefined until written
// and need no clearing pass.
// Registers over APB: 0 num_eq_rows, 1 num_ineq_rows, 2 bound_tolerance,
// 3 feas_tolerance at byte addresses 0, 4, 8, 12.
`timescale 1ns / 1ps
module lattice_step_score_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic [4:0]         row_index,
	input  logic [5:0]         var_index,
	input  logic               step_up,
	input  logic signed [47:0] value,
	input  logic signed [15:0] lower_limit,
	input  logic signed [15:0] upper_limit,
	input  logic signed [15:0] start_position,
	output logic               done,
	output logic               accepted,
	output logic               feasible,
	output logic signed [47:0] objective_value,
	output logic [6:0]         out_of_bound_count
);
	// config registers
	logic [5:0]  num_eq_q, num_ineq_q;
	logic [6:0]  bnd_tol_q;
	logic [30:0] feas_tol_q;
	logic        wr_en;
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_eq_q <= '0; num_ineq_q <= '0; bnd_tol_q <= 7'd1; feas_tol_q <= 31'd66;
		end else if (wr_en) begin
			unique case (lssu_pkg::reg_idx_t'(paddr[3:2]))
				lssu_pkg::REG_NUM_EQ:   num_eq_q <= pwdata[5:0];
				lssu_pkg::REG_NUM_INEQ: num_ineq_q <= pwdata[5:0];
				lssu_pkg::REG_BND_TOL:  bnd_tol_q <= pwdata[6:0];
				lssu_pkg::REG_FEAS_TOL: feas_tol_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (lssu_pkg::reg_idx_t'(paddr[3:2]))
			lssu_pkg::REG_NUM_EQ:   prdata = {26'd0, num_eq_q};
			lssu_pkg::REG_NUM_INEQ: prdata = {26'd0, num_ineq_q};
			lssu_pkg::REG_BND_TOL:  prdata = {25'd0, bnd_tol_q};
			lssu_pkg::REG_FEAS_TOL: prdata = {1'b0, feas_tol_q};
			default:                prdata = '0;
		endcase
	end

	// active row counts, capped
	logic [6:0] tot_sum;
	logic [5:0] rows_eq, rows_tot;
	assign tot_sum = {1'b0, num_eq_q} + {1'b0, num_ineq_q};
	assign rows_eq = (num_eq_q > 6'(lssu_pkg::MaxRows)) ? 6'(lssu_pkg::MaxRows) : num_eq_q;
	assign rows_tot = (tot_sum > 7'(lssu_pkg::MaxRows)) ? 6'(lssu_pkg::MaxRows) : tot_sum[5:0];

	// memories
	logic signed [15:0] pos_mem [lssu_pkg::MaxVars];
	logic signed [15:0] lo_mem  [lssu_pkg::MaxVars];
	logic signed [15:0] hi_mem  [lssu_pkg::MaxVars];
	logic signed [31:0] oc_mem  [lssu_pkg::MaxVars];
	logic signed [8:0]  viol_mem [lssu_pkg::MaxVars];
	logic signed [31:0] coef_mem [lssu_pkg::MaxRows * lssu_pkg::MaxVars];
	logic signed [47:0] res_mem [lssu_pkg::MaxRows];
	// nonzero-violation flags; the violation memory value is only used where set
	logic [lssu_pkg::MaxVars-1:0] viol_nz_q;

	// latched step word
	logic [5:0]         var_q;
	logic               up_q;

	lssu_pkg::state_t state_q, state_d;
	logic [5:0] cnt_q;         // row sweep counter
	logic       phase_q;       // 0 = issue read, 1 = write back or check
	logic       acc_q, feas_q;
	logic signed [47:0] score_q;
	logic [6:0] vcount_q;

	// read data
	logic signed [15:0] pos_rd, lo_rd, hi_rd;
	logic signed [31:0] oc_rd, coef_rd;
	logic signed [8:0]  viol_rd;
	logic signed [47:0] res_rd;
	logic [4:0] rd_row;
	logic [5:0] vidx;
	logic       do_upd;

	assign busy = (state_q != lssu_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lssu_pkg::ST_IDLE: if (start)
				state_d = (cmd == 3'(lssu_pkg::CMD_STEP)) ? lssu_pkg::ST_VAR : lssu_pkg::ST_CHK;
			lssu_pkg::ST_VAR:  if (phase_q) state_d = do_upd ? lssu_pkg::ST_UPD : lssu_pkg::ST_CHK;
			lssu_pkg::ST_UPD:  if (cnt_q == rows_tot && !phase_q) state_d = lssu_pkg::ST_CHK;
			lssu_pkg::ST_CHK:  if (cnt_q == rows_tot && !phase_q) state_d = lssu_pkg::ST_OUT;
			lssu_pkg::ST_OUT:  state_d = lssu_pkg::ST_IDLE;
			default: state_d = lssu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lssu_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// step arithmetic on the variable read data
	logic signed [16:0] pos_sum;
	logic signed [15:0] pos_new;
	logic signed [17:0] lv, uv;
	logic signed [9:0]  vsum;
	logic signed [8:0]  vnew, vold;
	logic [8:0]         vmag;
	logic               step_ok;
	always_comb begin
		vold = viol_nz_q[var_q] ? viol_rd : 9'sd0;
		vmag = '0;
		pos_sum = 17'(pos_rd) + (up_q ? 17'sd1 : -17'sd1);
		if (pos_sum > 17'sd32767) pos_new = 16'sh7FFF;
		else if (pos_sum < -17'sd32768) pos_new = 16'sh8000;
		else pos_new = pos_sum[15:0];
		lv = 18'(pos_new) - 18'(lo_rd);
		uv = 18'(pos_new) - 18'(hi_rd);
		vsum = 10'(vold) + (up_q ? 10'sd1 : -10'sd1);
		step_ok = 1'b1;
		if (vold == 9'sd0) begin
			if (lv < 0) vnew = (lv < -18'sd256) ? -9'sd256 : lv[8:0];
			else if (uv > 0) vnew = (uv > 18'sd255) ? 9'sd255 : uv[8:0];
			else vnew = 9'sd0;
		end else begin
			if (vsum > 10'sd255) vnew = 9'sd255;
			else if (vsum < -10'sd256) vnew = -9'sd256;
			else vnew = vsum[8:0];
			vmag = vnew[8] ? 9'(-vnew) : vnew;
			if (vnew != 9'sd0 && vmag > {2'b0, bnd_tol_q}) step_ok = 1'b0;
		end
		do_upd = step_ok;
	end

	// row address: during update phase 0 reads row cnt, phase 1 writes it
	assign rd_row = cnt_q[4:0];
	assign vidx = (state_q == lssu_pkg::ST_IDLE) ? var_index : var_q;

	// memory ports
	always_ff @(posedge clk) begin
		if (state_q == lssu_pkg::ST_IDLE && start) begin
			unique case (cmd)
				3'(lssu_pkg::CMD_COEF): coef_mem[{row_index, var_index}] <=
					lssu_pkg::sat32(value);
				3'(lssu_pkg::CMD_VAR): begin
					pos_mem[var_index] <= start_position;
					lo_mem[var_index] <= lower_limit;
					hi_mem[var_index] <= upper_limit;
					oc_mem[var_index] <= lssu_pkg::sat32(value);
				end
				default: ;
			endcase
		end
		if (state_q == lssu_pkg::ST_IDLE && start && cmd == 3'(lssu_pkg::CMD_RESID))
			res_mem[row_index] <= value;
		if (state_q == lssu_pkg::ST_VAR && phase_q) begin
			pos_mem[var_q] <= pos_new;
			viol_mem[var_q] <= vnew;
		end
		if (state_q == lssu_pkg::ST_UPD && phase_q)
			res_mem[rd_row] <= lssu_pkg::sat48(49'(res_rd) -
				(up_q ? 49'(coef_rd) : -49'(coef_rd)));
		pos_rd <= pos_mem[vidx];
		lo_rd <= lo_mem[vidx];
		hi_rd <= hi_mem[vidx];
		oc_rd <= oc_mem[vidx];
		viol_rd <= viol_mem[vidx];
		coef_rd <= coef_mem[{rd_row, var_q}];
		res_rd <= res_mem[rd_row];
	end

	// latched step word
	always_ff @(posedge clk) begin
		if (state_q == lssu_pkg::ST_IDLE && start) begin
			var_q <= var_index; up_q <= step_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viol_nz_q <= '0;
			vcount_q <= '0; score_q <= '0; cnt_q <= '0; phase_q <= 1'b0;
			acc_q <= 1'b0; feas_q <= 1'b0;
		end else begin
			// violation flags and count
			if (state_q == lssu_pkg::ST_IDLE && start && cmd == 3'(lssu_pkg::CMD_VAR)) begin
				viol_nz_q[var_index] <= 1'b0;
				if (viol_nz_q[var_index] && vcount_q != 0) vcount_q <= vcount_q - 7'd1;
			end else if (state_q == lssu_pkg::ST_VAR && phase_q) begin
				viol_nz_q[var_q] <= (vnew != 9'sd0);
				if (viol_nz_q[var_q] && vnew == 9'sd0 && vcount_q != 0)
					vcount_q <= vcount_q - 7'd1;
				else if (!viol_nz_q[var_q] && vnew != 9'sd0) vcount_q <= vcount_q + 7'd1;
			end
			unique case (state_q)
				lssu_pkg::ST_IDLE: begin
					cnt_q <= '0; phase_q <= 1'b0; feas_q <= 1'b1;
					if (start) begin
						acc_q <= (cmd <= 3'(lssu_pkg::CMD_STEP));
						if (cmd == 3'(lssu_pkg::CMD_SCORE)) score_q <= value;
					end
				end
				lssu_pkg::ST_VAR: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						acc_q <= step_ok;
						if (step_ok) score_q <= lssu_pkg::sat48(49'(score_q) +
							(up_q ? 49'(oc_rd) : -49'(oc_rd)));
					end
				end
				lssu_pkg::ST_UPD: begin
					if (cnt_q == rows_tot && !phase_q) cnt_q <= '0;
					else begin
						phase_q <= ~phase_q;
						if (phase_q) cnt_q <= cnt_q + 6'd1;
					end
				end
				lssu_pkg::ST_CHK: begin
					// phase 0 reads row, phase 1 checks it
					if (!(cnt_q == rows_tot && !phase_q)) begin
						phase_q <= ~phase_q;
						if (phase_q) begin
							cnt_q <= cnt_q + 6'd1;
							if (cnt_q < rows_eq) begin
								if ((res_rd[47] ? -res_rd : res_rd) > 48'(feas_tol_q))
									feas_q <= 1'b0;
							end else if (res_rd[47]) feas_q <= 1'b0;
						end
					end
				end
				lssu_pkg::ST_OUT: ;
				default: ;
			endcase
		end
	end

	// result word
	assign done = (state_q == lssu_pkg::ST_OUT);
	assign accepted = acc_q;
	assign feasible = feas_q && (vcount_q == 7'd0);
	assign objective_value = score_q;
	assign out_of_bound_count = vcount_q;
endmodule

/* sv/lssu_checker.sv */
// Checker: port-level properties of the walker core, bound to the top level.
`timescale 1ns / 1ps
module lssu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic feasible,
	input logic [6:0] out_of_bound_count
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accept");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_feas_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && feasible |-> out_of_bound_count == 7'd0)
		else $error("feasible with violations");
endmodule

bind lattice_step_score_update lssu_checker u_lssu_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.feasible(feasible), .out_of_bound_count(out_of_bound_count)
);

/* tb/testbench.sv */
// Testbench for lattice_step_score_update: directed rows, then random phases checked by a predictor.
`timescale 1ns / 1ps
module testbench;
	import lssu_pkg::*;

	localparam longint Q48Min = -64'sd140737488355328;
	localparam longint Q48Max = 64'sd140737488355327;
	localparam int CycleLimit = 2000000;
	localparam int PhaseWords = 435;

	typedef struct {
		logic [2:0]         op;
		logic [4:0]         row;
		logic [5:0]         vi;
		logic               up;
		logic signed [47:0] val;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [15:0] st;
	} word_t;

	typedef struct {
		logic               acc;
		logic               feas;
		logic signed [47:0] obj;
		logic [6:0]         cnt;
	} outcome_t;

	typedef struct {
		word_t    w;
		bit       typed;
		outcome_t res;
	} stim_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic start, busy;
	logic [2:0] cmd;
	logic [4:0] row_index;
	logic [5:0] var_index;
	logic step_up;
	logic signed [47:0] value;
	logic signed [15:0] lower_limit, upper_limit, start_position;
	logic done, accepted, feasible;
	logic signed [47:0] objective_value;
	logic [6:0] out_of_bound_count;

	lattice_step_score_update dut (.*);

	// walker state as the predictor sees it
	int     pos_m [MaxVars];
	int     lo_m [MaxVars];
	int     hi_m [MaxVars];
	int     ocoef_m [MaxVars];
	int     viol_m [MaxVars];
	int     viol_count;
	int     coef_m [MaxRows][MaxVars];
	longint resid_m [MaxRows];
	longint score_m;
	int     cfg_eq, cfg_ineq, cfg_btol;
	longint cfg_ftol;
	// which store entries have been loaded
	bit     var_set [MaxVars];
	bit     coef_set [MaxRows][MaxVars];
	bit     resid_set [MaxRows];

	outcome_t expect_q[$];
	int       fails;
	int       cycles;
	int       idle_pct;

	function automatic longint clamp(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic int active_rows();
		return (cfg_eq + cfg_ineq) < MaxRows ? cfg_eq + cfg_ineq : MaxRows;
	endfunction

	function automatic void set_viol(int v, int nv);
		if (viol_m[v] != 0 && nv == 0 && viol_count > 0) viol_count--;
		else if (viol_m[v] == 0 && nv != 0) viol_count++;
		viol_m[v] = nv;
	endfunction

	function automatic bit walker_feasible();
		int e, t;
		longint r;
		e = cfg_eq < MaxRows ? cfg_eq : MaxRows;
		t = active_rows();
		if (viol_count != 0) return 0;
		for (int j = 0; j < t; j++) begin
			r = resid_m[j];
			if (j < e) begin
				if (r < 0) r = -r;
				if (r > cfg_ftol) return 0;
			end else if (r < 0) return 0;
		end
		return 1;
	endfunction

	// move one variable; returns 0 when the held violation exceeds tolerance
	function automatic bit walk_step(int v, bit up);
		int s, nv, mag;
		longint lv, uv;
		s = up ? 1 : -1;
		pos_m[v] = int'(clamp(longint'(pos_m[v]) + s, -32768, 32767));
		if (viol_m[v] == 0) begin
			lv = longint'(pos_m[v]) - lo_m[v];
			uv = longint'(pos_m[v]) - hi_m[v];
			if (lv < 0) set_viol(v, int'(clamp(lv, -256, 255)));
			else if (uv > 0) set_viol(v, int'(clamp(uv, -256, 255)));
		end else begin
			nv = int'(clamp(longint'(viol_m[v]) + s, -256, 255));
			mag = nv < 0 ? -nv : nv;
			set_viol(v, nv);
			if (nv != 0 && mag > cfg_btol) return 0;
		end
		for (int j = 0; j < active_rows(); j++)
			resid_m[j] = clamp(resid_m[j] - longint'(s) * coef_m[j][v], Q48Min, Q48Max);
		score_m = clamp(score_m + longint'(s) * ocoef_m[v], Q48Min, Q48Max);
		return 1;
	endfunction

	// apply one command word and return the result word it should produce
	function automatic outcome_t predict_word(word_t w);
		outcome_t o;
		longint val;
		val = longint'(w.val);
		o.acc = 0;
		case (w.op)
			CMD_COEF: begin
				coef_m[w.row][w.vi] = int'(clamp(val, -64'sd2147483648, 64'sd2147483647));
				coef_set[w.row][w.vi] = 1;
				o.acc = 1;
			end
			CMD_RESID: begin
				resid_m[w.row] = val;
				resid_set[w.row] = 1;
				o.acc = 1;
			end
			CMD_VAR: begin
				pos_m[w.vi] = w.st;
				lo_m[w.vi] = w.lo;
				hi_m[w.vi] = w.hi;
				ocoef_m[w.vi] = int'(clamp(val, -64'sd2147483648, 64'sd2147483647));
				set_viol(w.vi, 0);
				var_set[w.vi] = 1;
				o.acc = 1;
			end
			CMD_SCORE: begin
				score_m = val;
				o.acc = 1;
			end
			CMD_STEP: o.acc = walk_step(w.vi, w.up);
			default: o.acc = 0;
		endcase
		o.feas = walker_feasible();
		o.obj = score_m[47:0];
		o.cnt = viol_count > 127 ? 7'd127 : 7'(viol_count);
		return o;
	endfunction

	function automatic word_t mk(logic [2:0] op, int row, int vi, bit up, longint val,
			int lo, int hi, int st);
		word_t w;
		w.op = op;
		w.row = 5'(row);
		w.vi = 6'(vi);
		w.up = up;
		w.val = val[47:0];
		w.lo = 16'(lo);
		w.hi = 16'(hi);
		w.st = 16'(st);
		return w;
	endfunction

	function automatic longint rand_val();
		longint v;
		case ($urandom_range(0, 4))
			0: v = {$urandom, $urandom};
			1: v = longint'($urandom_range(0, 400000)) - 200000;
			2: v = $urandom_range(0, 1) ? Q48Max : Q48Min;
			3: v = longint'(int'($urandom));
			default: v = longint'($urandom_range(0, 2000)) - 1000;
		endcase
		return longint'($signed(v[47:0]));
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("lattice_step_score_update regression: fail");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (done) begin
			if (expect_q.size() == 0) begin
				$display("%0t unexpected result word acc %0d obj %0d", $time, accepted,
					objective_value);
				fails++;
			end else begin
				e = expect_q.pop_front();
				if (accepted !== e.acc) begin
					$display("%0t accepted exp %0d got %0d", $time, e.acc, accepted);
					fails++;
				end
				if (feasible !== e.feas) begin
					$display("%0t feasible exp %0d got %0d", $time, e.feas, feasible);
					fails++;
				end
				if (objective_value !== e.obj) begin
					$display("%0t objective_value exp %0d got %0d", $time, e.obj,
						objective_value);
					fails++;
				end
				if (out_of_bound_count !== e.cnt) begin
					$display("%0t out_of_bound_count exp %0d got %0d", $time, e.cnt,
						out_of_bound_count);
					fails++;
				end
			end
		end
	end

	// drive one word, wait for acceptance, queue its result
	task automatic send_word(word_t w, bit typed, outcome_t typed_res);
		outcome_t o;
		start <= 1;
		cmd <= w.op;
		row_index <= w.row;
		var_index <= w.vi;
		step_up <= w.up;
		value <= w.val;
		lower_limit <= w.lo;
		upper_limit <= w.hi;
		start_position <= w.st;
		do @(posedge clk); while (busy);
		o = predict_word(w);
		expect_q = {expect_q, (typed ? typed_res : o)};
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send(word_t w);
		outcome_t none;
		none = '{0, 0, 0, 0};
		send_word(w, 0, none);
	endtask

	// hold off until every result is back and the block has settled
	task automatic drain();
		start <= 0;
		while (expect_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t r, logic [31:0] d);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {r, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		case (r)
			REG_NUM_EQ: cfg_eq = d[5:0];
			REG_NUM_INEQ: cfg_ineq = d[5:0];
			REG_BND_TOL: cfg_btol = d[6:0];
			default: cfg_ftol = d[30:0];
		endcase
	endtask

	// random word; steps only on variables whose column is fully loaded
	task automatic send_random();
		word_t w;
		int v, k, miss, lo, hi, st;
		w = mk(3'($urandom_range(0, 7)), $urandom, $urandom, 1'($urandom), rand_val(),
			$urandom, $urandom, $urandom);
		v = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 63);
		w.vi = 6'(v);
		k = $urandom_range(0, 99);
		if (k < 50) begin
			miss = -1;
			for (int j = active_rows() - 1; j >= 0; j--)
				if (!coef_set[j][v]) miss = j;
			if (!var_set[v]) k = 60;
			else if (miss >= 0) begin
				w.op = CMD_COEF;
				w.row = 5'(miss);
			end else w.op = CMD_STEP;
		end
		if (k >= 50 && k < 60) w.op = CMD_COEF;
		else if (k >= 60 && k < 72) begin
			w.op = CMD_VAR;
			if ($urandom_range(0, 3) != 0) begin
				st = $urandom_range(0, 100) - 50;
				lo = st - $urandom_range(0, 3);
				hi = st + $urandom_range(0, 3);
				if ($urandom_range(0, 5) == 0) st = st + $urandom_range(0, 6) - 3;
				w.lo = 16'(lo);
				w.hi = 16'(hi);
				w.st = 16'(st);
			end
		end else if (k >= 72 && k < 84) w.op = CMD_RESID;
		else if (k >= 84 && k < 92) w.op = CMD_SCORE;
		else if (k >= 92) w.op = 3'($urandom_range(5, 7));
		send(w);
	endtask

	initial begin
		stim_row_t rows[$];
		stim_row_t sr;
		int eqs[4], ineqs[4], btols[4], idles[4];
		logic [31:0] ftols[4];

		fails = 0;
		cycles = 0;
		idle_pct = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		start = 0;
		cmd = CMD_COEF;
		row_index = 0;
		var_index = 0;
		step_up = 0;
		value = 0;
		lower_limit = 0;
		upper_limit = 0;
		start_position = 0;
		foreach (viol_m[i]) begin
			viol_m[i] = 0;
			pos_m[i] = 0;
			lo_m[i] = 0;
			hi_m[i] = 0;
			ocoef_m[i] = 0;
			var_set[i] = 0;
		end
		foreach (coef_m[r, c]) begin
			coef_m[r][c] = 0;
			coef_set[r][c] = 0;
		end
		foreach (resid_m[r]) begin
			resid_m[r] = 0;
			resid_set[r] = 0;
		end
		viol_count = 0;
		score_m = 0;
		cfg_eq = 0;
		cfg_ineq = 0;
		cfg_btol = 1;
		cfg_ftol = 66;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed rows; no rows active, so nothing reads the row stores
		sr.typed = 1;
		sr.w = mk(CMD_SCORE, 0, 0, 0, Q48Max, 0, 0, 0);
		sr.res = '{1, 1, 48'sh7FFF_FFFF_FFFF, 0};
		rows = {rows, sr};
		sr.w = mk(CMD_SCORE, 31, 63, 1, Q48Min, -1, -1, -1);
		sr.res = '{1, 1, 48'sh8000_0000_0000, 0};
		rows = {rows, sr};
		sr.w = mk(3'd7, 31, 63, 1, -1, -1, -1, -1);
		sr.res = '{0, 1, 48'sh8000_0000_0000, 0};
		rows = {rows, sr};
		sr.w = mk(3'd5, 0, 0, 0, 0, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(3'd6, 0, 0, 0, 0, 0, 0, 0);
		rows = {rows, sr};
		sr.typed = 0;
		// position saturation at the top, wide objective coefficient
		sr.w = mk(CMD_VAR, 0, 63, 0, Q48Max, -32768, 32767, 32767);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 63, 1, 0, 0, 0, 0);
		rows = {rows, sr};
		// fresh violation, held violation past tolerance, back to zero
		sr.w = mk(CMD_VAR, 0, 0, 0, Q48Min, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 0, 1, 0, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 0, 1, 0, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 0, 0, 0, 0, 0, 0);
		rows = {rows, sr};
		// violation saturation below, position saturation at the bottom
		sr.w = mk(CMD_VAR, 0, 1, 0, 12345, 32767, 32767, -32768);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 1, 1, 0, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 1, 0, 0, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 1, 0, 0, 0, 0, 0);
		rows = {rows, sr};
		// rewrite clears the held violation
		sr.w = mk(CMD_VAR, 0, 1, 0, -7, -32768, 32767, 5);
		rows = {rows, sr};
		// upper-side fresh violation saturates at 255
		sr.w = mk(CMD_VAR, 0, 2, 0, 65536, -32768, -32768, 32767);
		rows = {rows, sr};
		sr.w = mk(CMD_STEP, 0, 2, 0, 0, 0, 0, 0);
		rows = {rows, sr};
		// narrow coefficient writes and residual extremes
		sr.w = mk(CMD_COEF, 31, 63, 0, Q48Max, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_COEF, 0, 0, 0, Q48Min, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_RESID, 31, 0, 0, Q48Min, 0, 0, 0);
		rows = {rows, sr};
		sr.w = mk(CMD_RESID, 0, 0, 0, Q48Max, 0, 0, 0);
		rows = {rows, sr};
		foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

		// load every residual while no row is active, so no scan sees an unloaded one
		for (int j = 0; j < MaxRows; j++)
			send(mk(CMD_RESID, j, $urandom, 1'($urandom), rand_val(), 0, 0, 0));

		// random phases under several register settings
		eqs = '{2, 32, 0, 63};
		ineqs = '{3, 0, 32, 63};
		btols = '{3, 127, 0, 5};
		ftols = '{32'd100000, 32'h7FFF_FFFF, 32'd0, 32'd66};
		idles = '{31, 83, 0, 0};
		for (int p = 0; p < 4; p++) begin
			drain();
			reg_write(REG_NUM_EQ, eqs[p]);
			reg_write(REG_NUM_INEQ, ineqs[p]);
			reg_write(REG_BND_TOL, btols[p]);
			reg_write(REG_FEAS_TOL, p == 3 ? $urandom : ftols[p]);
			idle_pct = idles[p];
			for (int n = 0; n < PhaseWords; n++) send_random();
		end

		drain();
		if (fails == 0) $display("lattice_step_score_update regression: pass");
		else $display("lattice_step_score_update regression: fail");
		$finish;
	end
endmodule
